### rtl/glob_path_matcher_assert.svh
// Assertion macros for the glob path matcher checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef GLOB_PATH_MATCHER_ASSERT_SVH
`define GLOB_PATH_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define GPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gpm_pkg.sv
// Shared types, codes and helpers for the glob path matcher.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package gpm_pkg;

  localparam int IDX_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 7;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_QMARK = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;

  // Input word modes.
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_PATH  = 2'd1,
    MODE_QUERY = 2'd2
  } gpm_mode_e;

  // Operations carried through the queue.
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_PATH,
    OP_QUERY
  } gpm_op_e;

  typedef struct packed {
    gpm_op_e             op;
    logic [IDX_W-1:0]    idx;
    logic [BYTE_W-1:0]   data;
    logic                first;
    logic                last;
  } gpm_item_t;

  // Affine map over the OR/AND semiring: x_out = a * x_in | b.
  typedef struct packed {
    logic [2:0][2:0] a;
    logic [2:0]      b;
  } gpm_aff_t;

  // Apply lo first, then hi.
  function automatic gpm_aff_t gpm_compose(input gpm_aff_t hi, input gpm_aff_t lo);
    gpm_aff_t r;
    for (int rr = 0; rr < 3; rr++) begin
      for (int cc = 0; cc < 3; cc++) begin
        r.a[rr][cc] = |(hi.a[rr] & {lo.a[2][cc], lo.a[1][cc], lo.a[0][cc]});
      end
      r.b[rr] = hi.b[rr] | (|(hi.a[rr] & lo.b));
    end
    return r;
  endfunction

endpackage

### rtl/glob_path_matcher.sv
// glob_path_matcher: matches streamed path bytes against a stored glob pattern
// ('?', '*', '**' and '**/' with zero-directory matching; anything else literal).
// Load the pattern with mode 0 words (pattern_index, byte_value) and set its
// length through the cfg write port; a length of zero never matches and lengths
// above MaxPattern saturate. Stream a path as mode 1 words, marking the first
// byte with path_first (restarts the active offset set) and the last with
// path_last (returns one matched word). A mode 2 word asks whether the empty path
// matches and returns one word. Mode 3 and out-of-range pattern writes are taken
// and ignored. Throughput is one input word per clock while the queue has room; a
// word passes through the queue and then the result register. The rate rests on
// the combinational active-set update in the back end: per-offset consume logic
// followed by a log2(MaxPattern+1)-level prefix network that closes the set over
// the epsilon moves of '*' runs. A two-word queue separates the decoding front
// end from the back end, so in_ready_o drops only when output backpressure fills
// that queue. Depends on gpm_pkg, gpm_front, gpm_fifo, gpm_back.
`timescale 1ns / 1ps

module glob_path_matcher #(
  parameter int MaxPattern = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic [gpm_pkg::IDX_W-1:0]     pattern_index_i,
  input  logic [gpm_pkg::BYTE_W-1:0]    byte_value_i,
  input  logic                          path_first_i,
  input  logic                          path_last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          matched_o,
  input  logic                          cfg_we_i,
  input  logic [gpm_pkg::LEN_W-1:0]     cfg_wdata_i
);

  logic               push, q_full, q_valid, q_pop;
  gpm_pkg::gpm_item_t push_item, q_item;

  // Decode the word and drop those that change nothing.
  gpm_front #(
    .MaxPattern(MaxPattern)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .pattern_index_i (pattern_index_i),
    .byte_value_i    (byte_value_i),
    .path_first_i    (path_first_i),
    .path_last_i     (path_last_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .item_o          (push_item)
  );

  // Hold decoded words while the back end waits on the output.
  gpm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // Advance the NFA, write the pattern store, register results.
  gpm_back #(
    .MaxPattern(MaxPattern)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .matched_o   (matched_o)
  );

endmodule

### rtl/gpm_front.sv
// Front end: accepts input words, decodes the mode and drops words with no effect.
// Depends on gpm_pkg.
`timescale 1ns / 1ps

module gpm_front #(
  parameter int MaxPattern = 64
) (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic [gpm_pkg::IDX_W-1:0]     pattern_index_i,
  input  logic [gpm_pkg::BYTE_W-1:0]    byte_value_i,
  input  logic                          path_first_i,
  input  logic                          path_last_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output gpm_pkg::gpm_item_t            item_o
);

  logic             keep;
  gpm_pkg::gpm_op_e op;

  always_comb begin
    keep = 1'b0;
    op   = gpm_pkg::OP_PATH;
    case (mode_i)
      gpm_pkg::MODE_WRITE: begin
        // drop writes past the end of the store
        keep = int'(pattern_index_i) < MaxPattern;
        op   = gpm_pkg::OP_WRITE;
      end
      gpm_pkg::MODE_PATH: begin
        keep = 1'b1;
        op   = gpm_pkg::OP_PATH;
      end
      gpm_pkg::MODE_QUERY: begin
        keep = 1'b1;
        op   = gpm_pkg::OP_QUERY;
      end
      default: begin
        keep = 1'b0;
      end
    endcase

    in_ready_o   = !q_full_i;
    push_o       = in_valid_i && in_ready_o && keep;
    item_o.op    = op;
    item_o.idx   = pattern_index_i;
    item_o.data  = byte_value_i;
    item_o.first = path_first_i;
    item_o.last  = path_last_i;
  end

endmodule

### rtl/gpm_fifo.sv
// Short decoupling queue between front end and NFA back end.
// Depends on gpm_pkg.
`timescale 1ns / 1ps

module gpm_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  gpm_pkg::gpm_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output gpm_pkg::gpm_item_t item_o
);

  localparam int Depth = gpm_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  gpm_pkg::gpm_item_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               do_push, do_pop;

  always_comb begin
    full_o  = cnt_q == CntW'(Depth);
    valid_o = cnt_q != '0;
    item_o  = mem_q[rd_ptr_q];
    do_push = push_i && !full_o;
    do_pop  = pop_i && valid_o;

    wr_ptr_d = wr_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    rd_ptr_d = rd_ptr_q;
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### rtl/gpm_closure.sv
// Offset kinds of the stored pattern and epsilon closure of an offset set.
// Closure runs as a parallel-prefix network of 3x3 boolean affine maps. Depends on gpm_pkg.
`timescale 1ns / 1ps

module gpm_closure #(
  parameter int MaxPattern = 64,
  localparam int LenW = $clog2(MaxPattern + 1),
  localparam int SetW = MaxPattern + 1
) (
  input  logic [MaxPattern-1:0][gpm_pkg::BYTE_W-1:0] pat_i,
  input  logic [LenW-1:0]                            len_i,
  input  logic [SetW-1:0]                            set_i,
  output logic [SetW-1:0]                            closed_o,
  output logic [MaxPattern-1:0]                      k_dss_o,
  output logic [MaxPattern-1:0]                      k_ds_o,
  output logic [MaxPattern-1:0]                      k_star_o,
  output logic [MaxPattern-1:0]                      k_one_o,
  output logic [MaxPattern-1:0]                      k_lit_o
);

  localparam int Levels = $clog2(SetW);

  logic [SetW-1:0]   sh1, sh2, sh3;
  gpm_pkg::gpm_aff_t lvl [Levels+1][SetW];

  for (genvar i = 0; i < MaxPattern; i++) begin : g_kind
    logic in0, star0, star1, slash2;
    assign in0   = LenW'(i) < len_i;
    assign star0 = in0 && (pat_i[i] == gpm_pkg::CH_STAR);
    if (i + 1 < MaxPattern) begin : g_n1
      assign star1 = (LenW'(i + 1) < len_i) && (pat_i[i+1] == gpm_pkg::CH_STAR);
    end else begin : g_n1_none
      assign star1 = 1'b0;
    end
    if (i + 2 < MaxPattern) begin : g_n2
      assign slash2 = (LenW'(i + 2) < len_i) && (pat_i[i+2] == gpm_pkg::CH_SLASH);
    end else begin : g_n2_none
      assign slash2 = 1'b0;
    end
    assign k_dss_o[i]  = star0 & star1 & slash2;
    assign k_ds_o[i]   = star0 & star1 & ~slash2;
    assign k_star_o[i] = star0 & ~star1;
    assign k_one_o[i]  = in0 && (pat_i[i] == gpm_pkg::CH_QMARK);
    assign k_lit_o[i]  = in0 & ~star0 & ~k_one_o[i];
  end

  // Edge into offset j from j-1, j-2, j-3.
  assign sh1 = SetW'(k_star_o) << 1;
  assign sh2 = SetW'(k_ds_o) << 2;
  assign sh3 = SetW'(k_dss_o) << 3;

  // State at offset j is (c[j], c[j-1], c[j-2]).
  for (genvar j = 0; j < SetW; j++) begin : g_leaf
    assign lvl[0][j].a[0] = {sh3[j], sh2[j], sh1[j]};
    assign lvl[0][j].a[1] = 3'b001;
    assign lvl[0][j].a[2] = 3'b010;
    assign lvl[0][j].b    = {2'b00, set_i[j]};
  end

  for (genvar k = 0; k < Levels; k++) begin : g_lvl
    for (genvar j = 0; j < SetW; j++) begin : g_node
      if (j >= (1 << k)) begin : g_cmb
        assign lvl[k+1][j] = gpm_pkg::gpm_compose(lvl[k][j], lvl[k][j - (1 << k)]);
      end else begin : g_pass
        assign lvl[k+1][j] = lvl[k][j];
      end
    end
  end

  for (genvar j = 0; j < SetW; j++) begin : g_out
    assign closed_o[j] = lvl[Levels][j].b[0];
  end

endmodule

### rtl/gpm_back.sv
// Back end: pattern store, length register, NFA active set and result register.
// Depends on gpm_pkg and gpm_closure.
`timescale 1ns / 1ps

module gpm_back #(
  parameter int MaxPattern = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  gpm_pkg::gpm_item_t            q_item_i,
  output logic                          q_pop_o,
  input  logic                          cfg_we_i,
  input  logic [gpm_pkg::LEN_W-1:0]     cfg_wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          matched_o
);

  localparam int LenW = $clog2(MaxPattern + 1);
  localparam int SetW = MaxPattern + 1;

  logic [MaxPattern-1:0][gpm_pkg::BYTE_W-1:0] pat_q, pat_d;
  logic [gpm_pkg::LEN_W-1:0] len_q, len_d;
  logic [LenW-1:0]           eff_len, eff_len_d;
  logic [SetW-1:0]           act_q, act_d, start_q, start_d, base, nx, closed;
  logic [MaxPattern-1:0]     k_dss, k_ds, k_star, k_one, k_lit;
  logic [MaxPattern-1:0]     loop_v, adv_v, jmp_v;
  logic                      out_valid_q, out_valid_d, matched_q, matched_d;
  logic                      res_op, out_free, pop, do_write, do_path, is_slash;

  function automatic logic [LenW-1:0] clip_len(input logic [gpm_pkg::LEN_W-1:0] l);
    if (int'(l) > MaxPattern) begin
      return LenW'(MaxPattern);
    end
    return LenW'(l);
  endfunction

  always_comb begin
    res_op   = (q_item_i.op == gpm_pkg::OP_QUERY) ||
               ((q_item_i.op == gpm_pkg::OP_PATH) && q_item_i.last);
    out_free = !out_valid_q || out_ready_i;
    pop      = q_valid_i && (!res_op || out_free);
    do_write = pop && (q_item_i.op == gpm_pkg::OP_WRITE);
    do_path  = pop && (q_item_i.op == gpm_pkg::OP_PATH);
    q_pop_o  = pop;

    for (int i = 0; i < MaxPattern; i++) begin
      pat_d[i] = (do_write && (int'(q_item_i.idx) == i)) ? q_item_i.data : pat_q[i];
    end
    len_d     = cfg_we_i ? cfg_wdata_i : len_q;
    eff_len   = clip_len(len_q);
    eff_len_d = clip_len(len_d);
  end

  // One NFA step over the closed set.
  always_comb begin
    base     = q_item_i.first ? start_q : act_q;
    is_slash = q_item_i.data == gpm_pkg::CH_SLASH;
    for (int i = 0; i < MaxPattern; i++) begin
      loop_v[i] = base[i] & (k_dss[i] | k_ds[i] | (k_star[i] & ~is_slash));
      adv_v[i]  = base[i] & ((k_one[i] & ~is_slash) |
                             (k_lit[i] & (q_item_i.data == pat_q[i])));
      jmp_v[i]  = base[i] & k_dss[i] & is_slash;
    end
    nx = SetW'(loop_v) | (SetW'(adv_v) << 1) | (SetW'(jmp_v) << 3);
  end

  gpm_closure #(
    .MaxPattern(MaxPattern)
  ) u_cur (
    .pat_i    (pat_q),
    .len_i    (eff_len),
    .set_i    (nx),
    .closed_o (closed),
    .k_dss_o  (k_dss),
    .k_ds_o   (k_ds),
    .k_star_o (k_star),
    .k_one_o  (k_one),
    .k_lit_o  (k_lit)
  );

  // Start set for the pattern as it stands after this edge.
  gpm_closure #(
    .MaxPattern(MaxPattern)
  ) u_start (
    .pat_i    (pat_d),
    .len_i    (eff_len_d),
    .set_i    (SetW'(1)),
    .closed_o (start_d),
    .k_dss_o  (),
    .k_ds_o   (),
    .k_star_o (),
    .k_one_o  (),
    .k_lit_o  ()
  );

  always_comb begin
    act_d = do_path ? closed : act_q;

    matched_d = matched_q;
    if (pop && res_op) begin
      if (q_item_i.op == gpm_pkg::OP_QUERY) begin
        matched_d = (eff_len != '0) && start_q[eff_len];
      end else begin
        matched_d = (eff_len != '0) && closed[eff_len];
      end
    end

    out_valid_d = out_valid_q;
    if (pop && res_op) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    out_valid_o = out_valid_q;
    matched_o   = matched_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      act_q       <= '0;
      start_q     <= SetW'(1);
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      act_q       <= act_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q     <= pat_d;
    matched_q <= matched_d;
  end

endmodule

### rtl/gpm_checker.sv
// Port-level checks for glob_path_matcher, attached with bind.
// Depends on gpm_pkg and glob_path_matcher_assert.svh.
`timescale 1ns / 1ps
`include "glob_path_matcher_assert.svh"

module gpm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [1:0]                mode_i,
  input logic                      path_last_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      matched_o,
  input logic                      cfg_we_i,
  input logic [gpm_pkg::LEN_W-1:0] cfg_wdata_i
);

  localparam int PendMax = gpm_pkg::QUEUE_DEPTH + 1;
  localparam int PendW   = $clog2(PendMax + 1);

  logic [PendW-1:0] pend_q, pend_d;
  logic             len_zero_q, len_zero_d;
  logic             res_in, res_out;

  // Count words that owe a result and have not been delivered.
  always_comb begin
    res_in  = in_valid_i && in_ready_o &&
              ((mode_i == gpm_pkg::MODE_QUERY) ||
               ((mode_i == gpm_pkg::MODE_PATH) && path_last_i));
    res_out = out_valid_o && out_ready_i;
    pend_d  = pend_q;
    if (res_in && !res_out) begin
      pend_d = pend_q + 1'b1;
    end else if (res_out && !res_in) begin
      pend_d = pend_q - 1'b1;
    end
    len_zero_d = cfg_we_i ? (cfg_wdata_i == '0) : len_zero_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      len_zero_q <= 1'b1;
    end else begin
      pend_q     <= pend_d;
      len_zero_q <= len_zero_d;
    end
  end

  `GPM_ASSERT_IMP(a_no_spurious_result, out_valid_o, pend_q != '0, "result word with no pending request")
  `GPM_ASSERT_IMP(a_zero_len_no_match, out_valid_o && len_zero_q, !matched_o, "match with zero pattern length")
  `GPM_ASSERT_IMP(a_backlog_stalls_input, pend_q == PendW'(PendMax), !in_ready_o, "input taken with full result backlog")
  `GPM_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(matched_o), "stalled result changed")

endmodule

bind glob_path_matcher gpm_checker u_gpm_checker (.*);
